/* rtl/fwpu_pkg.sv */
// Package for the float width pack/unpack unit.
// Holds shared types, request codes and the input-stage payload struct.
`default_nettype none
package fwpu_pkg;

    typedef enum logic {
        REQ_PACK   = 1'b0,
        REQ_UNPACK = 1'b1
    } t_req;

    localparam logic [0:0] CFG_TOTAL_BITS = 1'd0;
    localparam logic [0:0] CFG_EXP_BITS   = 1'd1;

    localparam logic [6:0] TB_RESET = 7'd32;
    localparam logic [3:0] EB_RESET = 4'd8;

    typedef struct packed {
        logic       req_type;
        logic [63:0] operand;
        logic [6:0]  tb;
        logic [3:0]  eb;
    } t_stage;

    typedef struct packed {
        logic [63:0] result;
        logic        range_error;
    } t_res;

endpackage
`default_nettype wire

/* rtl/fwpu_if.sv */
// Valid/ready stream interfaces for the float width pack/unpack unit.
// Depends on nothing but the language.
`default_nettype none
interface fwpu_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [63:0] operand;
    modport source (output valid, output req_type, output operand, input ready);
    modport sink (input valid, input req_type, input operand, output ready);
endinterface

interface fwpu_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result;
    logic        range_error;
    modport source (output valid, output result, output range_error, input ready);
    modport sink (input valid, input result, input range_error, output ready);
endinterface

interface fwpu_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [63:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/fwpu_cfg.sv */
// Configuration registers with saturation to the legal width ranges.
// Depends on fwpu_pkg and fwpu_if.
`default_nettype none
module fwpu_cfg
    import fwpu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    fwpu_cfg_if.sink        cfg,
    output logic [6:0]      o_tb,
    output logic [3:0]      o_eb
);
    logic [6:0] r_tb;
    logic [3:0] r_eb;
    logic [6:0] t;
    logic [3:0] e;

    assign cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tb <= TB_RESET;
            r_eb <= EB_RESET;
        end else if (cfg.valid) begin
            if (cfg.index == CFG_TOTAL_BITS) r_tb <= cfg.data[6:0];
            else r_eb <= cfg.data[3:0];
        end
    end

    always_comb begin
        t = r_tb;
        e = r_eb;
        if (t < 7'd8) t = 7'd8;
        if (t > 7'd64) t = 7'd64;
        if (e < 4'd2) e = 4'd2;
        if (e > 4'd11) e = 4'd11;
        if ({3'd0, e} > t - 7'd1) e = 4'(t - 7'd1);
    end
    assign o_tb = t;
    assign o_eb = e;
endmodule
`default_nettype wire

/* rtl/fwpu_core.sv */
// Combinational pack and unpack datapath between the input and result registers.
// Depends on fwpu_pkg.
`default_nettype none
module fwpu_core
    import fwpu_pkg::*;
(
    input  t_stage i_stage,
    output t_res   o_res
);
    logic [63:0] x;
    logic [6:0]  tb, fb;
    logic [3:0]  eb;
    logic [12:0] bias;
    // pack
    logic        s;
    logic [10:0] ex;
    logic [51:0] m, mn;
    logic [5:0]  p;
    logic        found;
    logic signed [13:0] e, biased, emax;
    logic [63:0] frac, pres;
    logic        perr;
    // unpack
    logic [63:0] tmask, w, fr, q0, rem, half, dmask, ures, sig, v, krem, khalf, kmask;
    logic [127:0] wide;
    logic [6:0]  d, k;
    logic        us;
    logic [10:0] ecode;
    logic signed [13:0] ue;
    logic [52:0] q;

    always_comb begin
        x  = i_stage.operand;
        tb = i_stage.tb;
        eb = i_stage.eb;
        fb = tb - {3'd0, eb} - 7'd1;
        bias = (13'd1 << (eb - 4'd1)) - 13'd1;
        s  = x[63];
        ex = x[62:52];
        m  = x[51:0];
        p = '0;
        found = 1'b0;
        for (int i = 0; i < 52; i++) begin
            if (m[i]) begin
                p = 6'(i);
                found = 1'b1;
            end
        end
        mn = m << (6'd52 - p);
        pres = '0;
        perr = 1'b0;
        if (ex == 11'h7FF) begin
            perr = 1'b1;
            e = '0;
        end else if (ex == 11'd0) begin
            e = $signed({8'd0, p}) - 14'sd1074;
        end else begin
            e = $signed({3'd0, ex}) - 14'sd1023;
        end
        if (ex == 11'd0) m = mn;
        biased = e + $signed({1'b0, bias});
        emax = $signed({1'b0, (13'd1 << eb) - 13'd1});
        if (fb <= 7'd52) frac = {12'd0, m} >> (7'd52 - fb);
        else frac = {12'd0, m} << (fb - 7'd52);
        if (ex != 11'h7FF && !(ex == 11'd0 && !found)) begin
            if (biased < 0 || biased > emax) perr = 1'b1;
            else pres = ({63'd0, s} << (tb - 7'd1)) |
                        ({50'd0, biased} << fb) | frac;
        end

        tmask = (tb >= 7'd64) ? '1 : ((64'd1 << tb) - 64'd1);
        w  = x & tmask;
        us = w[6'(tb - 7'd1)];
        wide = {64'd0, w} >> fb;
        ecode = 11'(wide[10:0] & ((11'd1 << eb) - 11'd1));
        ue = $signed({3'd0, ecode}) - $signed({1'b0, bias});
        fr = w & ((64'd1 << fb) - 64'd1);
        d = fb - 7'd52;
        dmask = (64'd1 << d) - 64'd1;
        rem = fr & dmask;
        half = 64'd1 << (d - 7'd1);
        if (fb <= 7'd52) begin
            q0 = fr << (7'd52 - fb);
            q = q0[52:0];
        end else begin
            q0 = fr >> d;
            q = q0[52:0];
            if (rem > half || (rem == half && q0[0])) q = q + 53'd1;
            if (q[52]) begin
                q = '0;
                ue = ue + 14'sd1;
            end
        end
        sig = {11'd0, 1'b1, q[51:0]};
        k = 7'(-14'sd1022 - ue);
        kmask = (64'd1 << k) - 64'd1;
        v = sig >> k;
        krem = sig & kmask;
        khalf = 64'd1 << (k - 7'd1);
        if (w == 64'd0) ures = '0;
        else if (ue > 14'sd1023) ures = {us, 11'h7FF, 52'd0};
        else if (ue >= -14'sd1022) ures = {us, 11'(ue + 14'sd1023), q[51:0]};
        else if (ue < -14'sd1076) ures = {us, 63'd0};
        else begin
            if (krem > khalf || (krem == khalf && v[0])) v = v + 64'd1;
            ures = {us, v[62:0]};
        end

        if (i_stage.req_type == REQ_UNPACK) begin
            o_res.result = ures;
            o_res.range_error = 1'b0;
        end else begin
            o_res.result = pres;
            o_res.range_error = perr;
        end
    end
endmodule
`default_nettype wire

/* rtl/float_width_pack_unpack_unit.sv */
// Top level of the float width pack/unpack unit.
// A beat passes the input register, then the combinational core, then the result register.
// Throughput: one beat per cycle unless the output stalls, set by the single-pass core.
// Reset: synchronous active-low; clears both valid flags and sets widths to 32 and 8.
// Depends on fwpu_pkg, fwpu_if, fwpu_cfg and fwpu_core.
`default_nettype none
module float_width_pack_unpack_unit
    import fwpu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fwpu_in_if.sink   in_ch,
    fwpu_out_if.source out_ch,
    fwpu_cfg_if.sink  cfg
);
    logic [6:0] tb;
    logic [3:0] eb;
    t_stage r_stage;
    logic   r_sv, r_ov;
    t_res   r_res, res;
    logic   adv;

    fwpu_cfg u_cfg (.i_clk, .i_rst_n, .cfg, .o_tb(tb), .o_eb(eb));
    fwpu_core u_core (.i_stage(r_stage), .o_res(res));

    assign adv = !r_ov || out_ch.ready;
    assign in_ch.ready = adv || !r_sv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (adv) r_ov <= r_sv;
            if (in_ch.ready) r_sv <= in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ch.ready) r_stage <= '{in_ch.req_type, in_ch.operand, tb, eb};
        if (adv) r_res <= res;
    end

    assign out_ch.valid = r_ov;
    assign out_ch.result = r_res.result;
    assign out_ch.range_error = r_res.range_error;
endmodule
`default_nettype wire

/* rtl/fwpu_checker.sv */
// Port-level checker for the float width pack/unpack unit, bound to the top level.
// Depends on the handshake and result signals of the top level's channel ports.
`default_nettype none
module fwpu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [63:0] i_result,
    input wire logic        i_range_error
);
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_result))
        else $error("result changed under stall");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_range_error |-> i_result == 64'd0)
        else $error("range error with nonzero result");
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked while output empty");
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> ##1 i_out_valid)
        else $error("accepted beat produced no result");
endmodule

bind float_width_pack_unpack_unit fwpu_checker u_chk (
    .i_clk, .i_rst_n,
    .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready),
    .i_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
    .i_result(out_ch.result), .i_range_error(out_ch.range_error)
);
`default_nettype wire

/* bench/float_width_pack_unpack_unit_tb.sv */
// Self-checking testbench for the float width pack/unpack unit.
// Drives pack and unpack beats over several width settings and checks every result beat
// against a built-in conversion predictor. Depends on fwpu_pkg, fwpu_if and the unit.
`default_nettype none
module testbench;
    import fwpu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [63:0] result;
        logic        range_error;
    } t_conv;

    class conv_scoreboard;
        t_conv pending[$];
        int    errors;

        function void note_beat(t_conv c);
            pending.push_back(c);
        endfunction

        function void check_beat(logic [63:0] res, logic rerr);
            t_conv c;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat %h err %b", $realtime, res, rerr);
                errors++;
                return;
            end
            c = pending.pop_front();
            if (c.result !== res) begin
                $display("%0t: result expected %h actual %h", $realtime, c.result, res);
                errors++;
            end
            if (c.range_error !== rerr) begin
                $display("%0t: range_error expected %b actual %b", $realtime,
                         c.range_error, rerr);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    fwpu_in_if  in_ch();
    fwpu_out_if out_ch();
    fwpu_cfg_if cfg();

    float_width_pack_unpack_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
    );

    always #5 i_clk = ~i_clk;

    conv_scoreboard sb = new();
    logic [6:0] width_reg = TB_RESET;
    logic [3:0] expw_reg  = EB_RESET;
    bit         stim_done;
    int         out_wait;

    function automatic logic [63:0] lmask(int n);
        return n >= 64 ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    function automatic t_conv convert(logic rq, logic [63:0] x);
        t_conv c;
        int tb, eb, fb, bias, e, biased, p, d, k;
        logic [63:0] m, w, fr, q, rem, half, sig, v;
        logic [10:0] ex;
        tb = width_reg; eb = expw_reg;
        c.result = '0; c.range_error = 1'b0;
        if (tb < 8) tb = 8;
        if (tb > 64) tb = 64;
        if (eb < 2) eb = 2;
        if (eb > 11) eb = 11;
        if (eb > tb - 1) eb = tb - 1;
        fb = tb - eb - 1;
        bias = (1 << (eb - 1)) - 1;
        if (rq == REQ_PACK) begin
            ex = x[62:52];
            m = {12'd0, x[51:0]};
            if (ex == 11'h7FF) begin
                c.range_error = 1'b1;
                return c;
            end
            if (ex == 0 && m == 0) return c;
            if (ex == 0) begin
                p = 51;
                while (m[p] == 1'b0) p--;
                e = p - 1074;
                m = (m << (52 - p)) & lmask(52);
            end else begin
                e = int'(ex) - 1023;
            end
            biased = e + bias;
            if (biased < 0 || biased > (1 << eb) - 1) begin
                c.range_error = 1'b1;
                return c;
            end
            fr = fb <= 52 ? m >> (52 - fb) : m << (fb - 52);
            c.result = (64'(x[63]) << (tb - 1)) | (64'(biased) << fb) | fr;
            return c;
        end
        w = x & lmask(tb);
        if (w == 0) return c;
        e = int'((w >> fb) & lmask(eb)) - bias;
        fr = w & lmask(fb);
        if (fb <= 52) begin
            q = fr << (52 - fb);
        end else begin
            d = fb - 52;
            rem = fr & lmask(d);
            half = 64'd1 << (d - 1);
            q = fr >> d;
            if (rem > half || (rem == half && q[0])) begin
                q++;
                if (q > lmask(52)) begin
                    q = 0;
                    e++;
                end
            end
        end
        c.result[63] = w[tb - 1];
        if (e > 1023) begin
            c.result[62:52] = 11'h7FF;
        end else if (e >= -1022) begin
            c.result[62:0] = {11'(e + 1023), q[51:0]};
        end else begin
            k = -1022 - e;
            if (k <= 54) begin
                sig = (64'd1 << 52) | q;
                v = sig >> k;
                rem = sig & lmask(k);
                half = 64'd1 << (k - 1);
                if (rem > half || (rem == half && v[0])) v++;
                c.result[62:0] = v[62:0];
            end
        end
        return c;
    endfunction

    task automatic write_reg(logic [0:0] idx, logic [63:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge i_clk); while (!cfg.ready);
        if (idx == CFG_TOTAL_BITS) width_reg = val[6:0];
        else expw_reg = val[3:0];
        cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_beat(logic rq, logic [63:0] op);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.req_type <= rq;
        in_ch.operand  <= op;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_beat(convert(rq, op));
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] rand_double();
        logic [63:0] x;
        x = rand64();
        case ($urandom_range(0, 9))
            0: x[62:52] = 11'h7FF;
            1: x[62:52] = 11'h000;
            2: x[62:52] = 11'(1023 + $urandom_range(0, 40) - 20);
            3, 4, 5, 6: x[62:52] = 11'(1023 + $urandom_range(0, 2100) - 1050);
            default: ;
        endcase
        return x;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_wait = $urandom_range(0, 7);
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                sb.check_beat(out_ch.result, out_ch.range_error);
                out_wait = $urandom_range(0, 7);
            end else if (out_wait > 0) begin
                out_wait--;
            end
            out_ch.ready <= (out_wait == 0);
        end
    end

    initial begin
        logic [6:0] widths[6];
        logic [3:0] expws[6];
        widths = '{7'd8, 7'd64, 7'd16, 7'd0, 7'd127, 7'd40};
        expws  = '{4'd2, 4'd11, 4'd5, 4'd0, 4'd15, 4'd11};
        in_ch.valid = 1'b0; in_ch.req_type = 1'b0; in_ch.operand = '0;
        cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_beat(REQ_PACK, 64'h0);
        send_beat(REQ_PACK, 64'h8000_0000_0000_0000);
        send_beat(REQ_PACK, 64'h7FF0_0000_0000_0000);
        send_beat(REQ_PACK, 64'hFFF8_0000_0000_0001);
        send_beat(REQ_PACK, 64'h0000_0000_0000_0001);
        send_beat(REQ_PACK, 64'h000F_FFFF_FFFF_FFFF);
        send_beat(REQ_PACK, 64'h3FF0_0000_0000_0000);
        send_beat(REQ_PACK, 64'hC7EF_FFFF_FFFF_FFFF);
        send_beat(REQ_PACK, 64'h47F0_0000_0000_0000);
        send_beat(REQ_UNPACK, 64'h0);
        send_beat(REQ_UNPACK, 64'hFFFF_FFFF_0000_0000);
        send_beat(REQ_UNPACK, 64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(REQ_UNPACK, 64'h8000_0000);
        drain();
        write_reg(CFG_TOTAL_BITS, 64'd64);
        write_reg(CFG_EXP_BITS, 64'd2);
        send_beat(REQ_UNPACK, 64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(REQ_UNPACK, 64'h1800_0000_0000_0800);
        send_beat(REQ_UNPACK, 64'h0000_0000_0000_0C00);
        send_beat(REQ_PACK, 64'hBFF8_0000_0000_0001);
        drain();
        write_reg(CFG_EXP_BITS, 64'd11);
        send_beat(REQ_UNPACK, 64'h0000_0000_0000_0001);
        send_beat(REQ_UNPACK, 64'h7FFF_FFFF_FFFF_FFFF);
        foreach (widths[s]) begin
            drain();
            write_reg(CFG_TOTAL_BITS, {$urandom(), 25'd0, widths[s]});
            write_reg(CFG_EXP_BITS, {$urandom(), 28'd0, expws[s]});
            for (int i = 0; i < 200; i++) begin
                if ($urandom_range(0, 1)) send_beat(REQ_PACK, rand_double());
                else send_beat(REQ_UNPACK, rand64());
                if (i == 100) drain();
            end
        end
        drain();
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("testbench: errors");
        $finish;
    end
endmodule
`default_nettype wire
